>>> rtl/ptp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptp_pkg: shared types and constants
// Widths, status codes and stage structs for the point transform unit.
// ---------------------------------------------------------------------------
package ptp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_REGS = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int COORD_W = 32;
  localparam int STATUS_W = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;

  localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DEN_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SAT = 2'd2;

  // dot products after the front end
  typedef struct packed {
    logic signed [COORD_W-1:0] nx;
    logic signed [COORD_W-1:0] ny;
    logic signed [COORD_W-1:0] nz;
    logic signed [COORD_W-1:0] den;
    logic                      sat;
  } dot_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [STATUS_W-1:0]       status;
  } res_t;

  // 32-bit signed saturation of a wide value
  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [79:0] v,
                                                     output logic s);
    s = 1'b0;
    if (v > 80'sh7FFFFFFF) begin
      s = 1'b1;
      sat32 = 32'sh7FFFFFFF;
    end else if (v < -80'sh80000000) begin
      s = 1'b1;
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[COORD_W-1:0];
    end
  endfunction

endpackage

>>> rtl/ptp_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptp_if: valid/ready channel
// Generic request channel carrying a packed payload.
// ---------------------------------------------------------------------------
interface ptp_if #(
  parameter int W = 1
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/ptp_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptp_front: dot product pipeline
// Multiplies each point by the matrix rows, sums and saturates, flags saturation.
// ---------------------------------------------------------------------------
module ptp_front #(
  parameter int FRAC_BITS = ptp_pkg::FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_go,
  input  logic signed [31:0]       px,
  input  logic signed [31:0]       py,
  input  logic signed [31:0]       pz,
  input  logic [8*64-1:0]          mat,
  output logic                     out_vld,
  output ptp_pkg::dot_t            out_dot
);

  // stage 1: 12 products, translation terms pass through
  logic signed [63:0] prod_r [0:3][0:2];
  logic signed [31:0] trans_r [0:3];
  logic               v1_r, v2_r;
  ptp_pkg::dot_t      dot_r;

  always_ff @(posedge clk) begin
    for (int r = 0; r < 4; r++) begin
      prod_r[r][0] <= $signed(mat[r*128 +: 32]) * px;
      prod_r[r][1] <= $signed(mat[r*128+32 +: 32]) * py;
      prod_r[r][2] <= $signed(mat[r*128+64 +: 32]) * pz;
      trans_r[r]   <= $signed(mat[r*128+96 +: 32]);
    end
  end

  // stage 2: exact sum, floor shift, saturate
  logic signed [79:0] sum [0:3];
  logic signed [31:0] res [0:3];
  logic [3:0]         s;
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sum[r] = (80'(prod_r[r][0]) + 80'(prod_r[r][1]) + 80'(prod_r[r][2])) >>> FRAC_BITS;
      sum[r] = sum[r] + 80'(trans_r[r]);
      res[r] = ptp_pkg::sat32(sum[r], s[r]);
    end
  end

  always_ff @(posedge clk) begin
    dot_r.nx  <= res[0];
    dot_r.ny  <= res[1];
    dot_r.nz  <= res[2];
    dot_r.den <= res[3];
    dot_r.sat <= |s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_go;
      v2_r <= v1_r;
    end
  end

  assign out_vld = v2_r;
  assign out_dot = dot_r;

endmodule

>>> rtl/ptp_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptp_queue: decoupling fifo
// Small fifo between the dot product front and the divide back end.
// ---------------------------------------------------------------------------
module ptp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  ptp_pkg::dot_t wr_data,
  input  logic          rd_en,
  output logic          rd_vld,
  output ptp_pkg::dot_t rd_data,
  output logic [ptp_pkg::QUEUE_PTR_W:0] count
);
  localparam int PW = ptp_pkg::QUEUE_PTR_W;

  ptp_pkg::dot_t      mem_r [0:ptp_pkg::QUEUE_DEPTH-1];
  logic [PW-1:0]      wp_r, rp_r;
  logic [PW:0]        cnt_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(wr_en) - (PW+1)'(rd_en);
    end
  end

  assign rd_vld  = cnt_r != '0;
  assign rd_data = mem_r[rp_r];
  assign count   = cnt_r;
endmodule

>>> rtl/ptp_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptp_div: pipelined signed divider
// Restoring divide of |num|<<FRAC_BITS by |den|, one quotient bit per stage.
// ---------------------------------------------------------------------------
module ptp_div #(
  parameter int FRAC_BITS = ptp_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               adv,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic signed [31:0] quo,
  output logic               sat
);
  localparam int NW = 32 + FRAC_BITS;  // dividend magnitude width
  localparam int QW = NW;

  logic [NW-1:0] rem_r [0:NW];
  logic [NW-1:0] qd_r  [0:NW];
  logic [31:0]   d_r   [0:NW];
  logic          neg_r [0:NW];

  logic [31:0] an, ad;
  always_comb begin
    an = num[31] ? 32'(-num) : 32'(num);
    ad = den[31] ? 32'(-den) : 32'(den);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= '0;
      qd_r[0]  <= NW'({an, FRAC_BITS'(0)});
      d_r[0]   <= ad;
      neg_r[0] <= num[31] ^ den[31];
      for (int i = 0; i < NW; i++) begin
        logic [NW:0] t;
        t = {rem_r[i], qd_r[i][NW-1]};
        if (t >= (NW+1)'(d_r[i])) begin
          rem_r[i+1] <= NW'(t - (NW+1)'(d_r[i]));
          qd_r[i+1]  <= {qd_r[i][NW-2:0], 1'b1};
        end else begin
          rem_r[i+1] <= NW'(t);
          qd_r[i+1]  <= {qd_r[i][NW-2:0], 1'b0};
        end
        d_r[i+1]   <= d_r[i];
        neg_r[i+1] <= neg_r[i];
      end
    end
  end

  logic signed [QW+1:0] sq;
  logic signed [79:0]   sw;
  always_comb begin
    sq  = neg_r[NW] ? -$signed({2'b0, qd_r[NW]}) : $signed({2'b0, qd_r[NW]});
    sw  = 80'(sq);
    quo = ptp_pkg::sat32(sw, sat);
  end
endmodule

>>> rtl/ptp_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptp_back: perspective divide back end
// Pops the queue into three divider lanes and registers the result.
// ---------------------------------------------------------------------------
module ptp_back #(
  parameter int FRAC_BITS = ptp_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_vld,
  input  ptp_pkg::dot_t q_data,
  output logic          q_pop,
  ptp_if.source         res
);
  localparam int LAT = 32 + FRAC_BITS + 1;

  logic               adv;
  logic [LAT-1:0]     vld_r;
  logic [LAT-1:0]     zero_r;
  logic [LAT-1:0]     psat_r;
  logic signed [31:0] qx, qy, qz;
  logic               sx, sy, sz;
  ptp_pkg::res_t      out_r;
  logic               ov_r;
  ptp_pkg::res_t      r;

  // pipeline moves when the output slot is free or being taken, or the last stage is empty
  assign adv   = !ov_r || res.ready || !vld_r[LAT-1];
  assign q_pop = adv && q_vld;

  ptp_div #(.FRAC_BITS(FRAC_BITS)) u_dx (.clk, .adv, .num(q_data.nx), .den(q_data.den),
                                        .quo(qx), .sat(sx));
  ptp_div #(.FRAC_BITS(FRAC_BITS)) u_dy (.clk, .adv, .num(q_data.ny), .den(q_data.den),
                                        .quo(qy), .sat(sy));
  ptp_div #(.FRAC_BITS(FRAC_BITS)) u_dz (.clk, .adv, .num(q_data.nz), .den(q_data.den),
                                        .quo(qz), .sat(sz));

  always_ff @(posedge clk) begin
    if (adv) begin
      zero_r <= {zero_r[LAT-2:0], q_data.den == '0};
      psat_r <= {psat_r[LAT-2:0], q_data.sat};
    end
  end

  always_comb begin
    if (zero_r[LAT-1]) begin
      r = '{x: '0, y: '0, z: '0, status: ptp_pkg::STATUS_DEN_ZERO};
    end else begin
      r.x = qx;
      r.y = qy;
      r.z = qz;
      r.status = (psat_r[LAT-1] | sx | sy | sz) ? ptp_pkg::STATUS_SAT : ptp_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      if (adv) vld_r <= {vld_r[LAT-2:0], q_pop};
      if (adv) ov_r <= vld_r[LAT-1] || (ov_r && !res.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vld_r[LAT-1]) out_r <= r;
  end

  assign res.valid = ov_r;
  assign res.data  = out_r;
endmodule

>>> rtl/point_transform_perspective_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// point_transform_perspective_unit: 4x4 point transform with divide
// Usage:
//   in_*  : valid/ready request of point_x/y/z, signed Q16.16.
//   out_* : valid/ready request of out_x/y/z and status.
//   cfg_* : write enable, index 0..7, 64-bit data; written while idle.
// The front end takes one point per cycle while in_ready is high into a
// two stage multiply and sum pipeline and pushes the dot products into a
// four entry queue. The back end runs three pipelined dividers of
// 32+FRAC_BITS stages, one quotient bit per stage, then an output
// register. A Q16.16 point goes through these in order to out_valid;
// throughput is one point per clock while out_ready is high.
// in_ready drops only when the queue cannot absorb the front pipeline.
// When out_ready is low the back pipeline holds and the queue fills.
// Reset loads the identity matrix and empties all pipelines.
// ---------------------------------------------------------------------------
module point_transform_perspective_unit #(
  parameter int FRAC_BITS = ptp_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [31:0]                in_point_x,
  input  logic signed [31:0]                in_point_y,
  input  logic signed [31:0]                in_point_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [31:0]                out_x,
  output logic signed [31:0]                out_y,
  output logic signed [31:0]                out_z,
  output logic [ptp_pkg::STATUS_W-1:0]      out_status,
  input  logic                              cfg_we,
  input  logic [ptp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ptp_pkg::CFG_DATA_W-1:0]    cfg_data
);
  localparam logic [63:0] ONE = 64'(1) << FRAC_BITS;

  logic [8*64-1:0] mat_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r <= {ONE << 32, 64'd0, ONE, 64'd0, 64'd0, ONE << 32, 64'd0, ONE};
    end else if (cfg_we) begin
      mat_r[cfg_index*64 +: 64] <= cfg_data;
    end
  end

  logic          fv, pop, qv;
  ptp_pkg::dot_t fd, qd;
  logic [ptp_pkg::QUEUE_PTR_W:0] cnt;
  logic [1:0]    inflight_r;
  logic          go;

  // two items can be in the front pipeline; leave room for them
  assign go       = in_valid && in_ready;
  assign in_ready = (32'(cnt) + 32'(inflight_r[0]) + 32'(inflight_r[1]))
                    < ptp_pkg::QUEUE_DEPTH;

  always_ff @(posedge clk) begin
    if (!rst_n) inflight_r <= '0;
    else inflight_r <= {inflight_r[0], go};
  end

  ptp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst_n, .in_go(go), .px(in_point_x), .py(in_point_y), .pz(in_point_z),
    .mat(mat_r), .out_vld(fv), .out_dot(fd)
  );

  ptp_queue u_queue (
    .clk, .rst_n, .wr_en(fv), .wr_data(fd), .rd_en(pop), .rd_vld(qv), .rd_data(qd),
    .count(cnt)
  );

  ptp_if #(.W($bits(ptp_pkg::res_t))) res_ch ();
  ptp_pkg::res_t ro;

  ptp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n, .q_vld(qv), .q_data(qd), .q_pop(pop), .res(res_ch.source)
  );

  assign ro           = res_ch.data;
  assign res_ch.ready = out_ready;
  assign out_valid    = res_ch.valid;
  assign out_x        = ro.x;
  assign out_y        = ro.y;
  assign out_z        = ro.z;
  assign out_status   = ro.status;
endmodule

>>> dv/tb_point_transform_perspective_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_point_transform_perspective_unit: self-checking bench for the 4x4
// perspective point transform
// Streams points through the unit under several matrices, random sender
// bursts and receiver stalls, and checks each result against a bit-exact
// fixed-point predictor kept in the bench.
// ---------------------------------------------------------------------------
module tb_point_transform_perspective_unit;

  localparam int FRAC = ptp_pkg::FRAC_BITS_DEF;
  localparam int DRAIN_CYCLES = 120;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC;

  typedef enum logic [ptp_pkg::CFG_IDX_W-1:0] {
    REG_ROW1_C12, REG_ROW1_C34, REG_ROW2_C12, REG_ROW2_C34,
    REG_ROW3_C12, REG_ROW3_C34, REG_ROW4_C12, REG_ROW4_C34
  } mtx_reg_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [ptp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ptp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  ptp_if #(.W(3*ptp_pkg::COORD_W)) in_ch ();
  ptp_if #(.W(3*ptp_pkg::COORD_W+ptp_pkg::STATUS_W)) out_ch ();

  logic signed [31:0] res_x, res_y, res_z;
  logic [ptp_pkg::STATUS_W-1:0] res_status;
  logic res_valid;

  assign out_ch.valid = res_valid;
  assign out_ch.data = {res_x, res_y, res_z, res_status};

  always #1 clk = ~clk;

  point_transform_perspective_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_point_x (in_ch.data[95:64]),
    .in_point_y (in_ch.data[63:32]),
    .in_point_z (in_ch.data[31:0]),
    .out_valid  (res_valid),
    .out_ready  (out_ch.ready),
    .out_x      (res_x),
    .out_y      (res_y),
    .out_z      (res_z),
    .out_status (res_status),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  logic [63:0] mtx_regs [ptp_pkg::NUM_REGS];
  ptp_pkg::res_t pending_q [$];
  int errors = 0;
  int cycles = 0;

  // sender burst shaping
  int burst_left = 0;
  int gap_max = 4;
  // receiver stall shaping
  int stall_pct = 25;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_cnt = 0;
  int hold_len = 0;

  function automatic logic signed [31:0] clamp32(input logic signed [79:0] v,
                                                 inout logic sat);
    if (v > 80'sh7FFFFFFF) begin
      sat = 1'b1;
      return 32'sh7FFFFFFF;
    end
    if (v < -80'sh80000000) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] matrix_entry(input int r, input int c);
    logic [63:0] w;
    w = mtx_regs[2*r + c/2];
    return (c % 2 == 0) ? w[31:0] : w[63:32];
  endfunction

  function automatic ptp_pkg::res_t project_point(input logic signed [31:0] px,
                                                  input logic signed [31:0] py,
                                                  input logic signed [31:0] pz);
    logic signed [79:0] acc, a, b, c, d, q;
    logic signed [31:0] dots [4];
    logic sat;
    ptp_pkg::res_t r;
    sat = 1'b0;
    for (int i = 0; i < 4; i++) begin
      a = matrix_entry(i, 0);
      b = matrix_entry(i, 1);
      c = matrix_entry(i, 2);
      d = matrix_entry(i, 3);
      acc = a * px + b * py + c * pz + (d <<< FRAC);
      dots[i] = clamp32(acc >>> FRAC, sat);
    end
    if (dots[3] == 0) begin
      r.x = '0;
      r.y = '0;
      r.z = '0;
      r.status = ptp_pkg::STATUS_DEN_ZERO;
      return r;
    end
    d = dots[3];
    a = dots[0];
    q = (a <<< FRAC) / d;
    r.x = clamp32(q, sat);
    a = dots[1];
    q = (a <<< FRAC) / d;
    r.y = clamp32(q, sat);
    a = dots[2];
    q = (a <<< FRAC) / d;
    r.z = clamp32(q, sat);
    r.status = sat ? ptp_pkg::STATUS_SAT : ptp_pkg::STATUS_OK;
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout, %0d results outstanding", $time, pending_q.size());
      $display("tb_point_transform_perspective_unit NOT OK");
      $finish;
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_cnt <= hold_len;
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    ptp_pkg::res_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_q.size() == 0) begin
        $display("%0t unexpected result x=%h y=%h z=%h status=%0d", $time,
                 got.x, got.y, got.z, got.status);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (got.x !== want.x) begin
          $display("%0t out_x expected %h actual %h", $time, want.x, got.x);
          errors++;
        end
        if (got.y !== want.y) begin
          $display("%0t out_y expected %h actual %h", $time, want.y, got.y);
          errors++;
        end
        if (got.z !== want.z) begin
          $display("%0t out_z expected %h actual %h", $time, want.z, got.z);
          errors++;
        end
        if (got.status !== want.status) begin
          $display("%0t status expected %0d actual %0d", $time, want.status,
                   got.status);
          errors++;
        end
      end
    end
  end

  task automatic send_point(input logic signed [31:0] px,
                            input logic signed [31:0] py,
                            input logic signed [31:0] pz);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(gap_max);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(12, 1);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= {px, py, pz};
    do @(posedge clk); while (!in_ch.ready);
    pending_q.push_back(project_point(px, py, pz));
    burst_left--;
  endtask

  task automatic wait_idle();
    if (in_ch.valid) in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input mtx_reg_t idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    mtx_regs[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_matrix(input logic [63:0] vals [ptp_pkg::NUM_REGS]);
    mtx_reg_t idx;
    for (int i = 0; i < ptp_pkg::NUM_REGS; i++) begin
      idx = mtx_reg_t'(i);
      write_reg(idx, vals[i]);
    end
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(4))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(8 * ONE)) - 4 * ONE;
      default: return $urandom;
    endcase
  endfunction

  // modest entries keep most results in range
  function automatic logic [31:0] rand_entry();
    if ($urandom_range(9) == 0) return $urandom;
    return $signed($urandom_range(6 * ONE)) - 3 * ONE;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    if ($urandom_range(7) == 0) return $urandom;
    return $signed($urandom_range(200 * ONE)) - 100 * ONE;
  endfunction

  task automatic test_identity_extremes();
    logic signed [31:0] vals [8];
    vals = '{32'sh0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh1, -32'sh1,
             ONE, -ONE, 32'sh55555555};
    for (int i = 0; i < 8; i++) send_point(vals[i], vals[(i+3)%8], vals[(i+5)%8]);
    wait_idle();
  endtask

  task automatic test_zero_denominator();
    logic [63:0] m [ptp_pkg::NUM_REGS];
    foreach (mtx_regs[i]) m[i] = mtx_regs[i];
    m[REG_ROW4_C12] = '0;
    m[REG_ROW4_C34] = {32'h0, ONE};
    load_matrix(m);
    // w = z, so z = 0 gives a zero denominator and tiny z a tiny one
    send_point(ONE, ONE, 32'sh0);
    send_point(32'sh7FFFFFFF, 32'sh80000000, 32'sh0);
    send_point(ONE, -ONE, 32'sh1);
    send_point(ONE, -ONE, -32'sh1);
    send_point(ONE, 2 * ONE, ONE);
    send_point(ONE, 2 * ONE, -ONE);
    wait_idle();
  endtask

  task automatic test_saturation();
    logic [63:0] m [ptp_pkg::NUM_REGS];
    m = '{{32'h7FFFFFFF, 32'h7FFFFFFF}, {32'h7FFFFFFF, 32'h80000000},
          {32'h80000000, 32'h80000000}, {32'h80000000, 32'h7FFFFFFF},
          {32'h0, 32'h7FFFFFFF}, {32'h7FFFFFFF, 32'h0},
          {32'h0, 32'h0}, {32'h0000_0001, 32'h0}};
    load_matrix(m);
    send_point(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_point(32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_point(ONE, ONE, 32'sh0);
    send_point(32'sh0, 32'sh0, 32'sh7FFFFFFF);
    send_point(32'sh0, 32'sh0, 32'sh80000000);
    wait_idle();
  endtask

  task automatic test_random_matrices(input int n_sets, input int per_set);
    logic [63:0] m [ptp_pkg::NUM_REGS];
    for (int s = 0; s < n_sets; s++) begin
      for (int i = 0; i < ptp_pkg::NUM_REGS; i++) m[i] = {rand_entry(), rand_entry()};
      if (s % 3 == 0) m[REG_ROW4_C34] = {ONE, rand_entry()};
      if (s % 5 == 4) for (int i = 0; i < ptp_pkg::NUM_REGS; i++) m[i] = {$urandom, $urandom};
      load_matrix(m);
      gap_max = (s % 2) ? 0 : 6;
      stall_pct = (s % 4 == 1) ? 0 : 10 * (s % 7);
      for (int k = 0; k < per_set; k++) begin
        if ($urandom_range(5) == 0) send_point(rand_word(), rand_word(), rand_word());
        else send_point(rand_coord(), rand_coord(), rand_coord());
      end
      wait_idle();
    end
  endtask

  // more points than the front, queue, divider pipeline and output can hold
  task automatic test_backpressure();
    hold_len = 300;
    hold_seq++;
    gap_max = 0;
    for (int k = 0; k < 80; k++) send_point(rand_coord(), rand_coord(), rand_coord());
    wait_idle();
    stall_pct = 25;
    gap_max = 4;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    foreach (mtx_regs[i]) mtx_regs[i] = '0;
    mtx_regs[REG_ROW1_C12] = {32'h0, ONE};
    mtx_regs[REG_ROW2_C12] = {ONE, 32'h0};
    mtx_regs[REG_ROW3_C34] = {32'h0, ONE};
    mtx_regs[REG_ROW4_C34] = {ONE, 32'h0};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_identity_extremes();
    test_zero_denominator();
    test_saturation();
    test_backpressure();
    test_random_matrices(12, 30);
    in_ch.valid <= 1'b0;
    if (errors == 0) begin
      $display("tb_point_transform_perspective_unit OK");
    end else begin
      $display("tb_point_transform_perspective_unit NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/ptp_pkg.sv
rtl/ptp_if.sv
rtl/ptp_front.sv
rtl/ptp_queue.sv
rtl/ptp_div.sv
rtl/ptp_back.sv
rtl/point_transform_perspective_unit.sv
dv/tb_point_transform_perspective_unit.sv
